/* hdl/hatc_pkg.sv */
package hatc_pkg;

	// scheduler call modes
	localparam logic [1:0] MODE_MANUAL = 2'd0;
	localparam logic [1:0] MODE_AUTO   = 2'd1;
	localparam logic [1:0] MODE_RESET  = 2'd2;

	// detection codes
	localparam logic [1:0] DET_CLEAR  = 2'd1;
	localparam logic [1:0] DET_DANGER = 2'd2;

	// configuration register indexes
	localparam logic [1:0] CFG_ALARM_DURATION = 2'd0;
	localparam logic [1:0] CFG_COOLDOWN       = 2'd1;
	localparam logic [1:0] CFG_STOP_RESEND    = 2'd2;

	localparam int          CFG_IDX_W  = 2;
	localparam int          CFG_DATA_W = 16;
	localparam int          SEC_W      = 8;
	localparam int          MS_W       = 16;
	localparam int          STOP_W     = 17;
	localparam int          MS_PER_SEC = 1000;

	localparam logic [SEC_W-1:0] DURATION_RST = 8'd3;
	localparam logic [SEC_W-1:0] COOLDOWN_RST = 8'd2;
	localparam logic [MS_W-1:0]  RESEND_RST   = 16'd1000;

endpackage

/* hdl/hazard_alarm_timer_with_cooldown.sv */
// Hazard alarm timer with cooldown, manual and auto alarm channels.
//
// Input channel (in_valid/in_ready): one scheduler call per transaction, carrying
// mode, detection and elapsed_ms. Output channel (out_valid/out_ready): exactly
// one result transaction per input, in order.
// The input stage register holds an accepted call; it moves into the result register
// once that register is free. Throughput: one call per cycle while the receiver keeps
// out_ready high. The alarm state is read and written back between the input stage
// register and the result register, so consecutive calls never wait on each other.
// Stall: while the result register is held by a stalled receiver, one more call
// may still be accepted into the input stage; after that in_ready drops until the
// result is taken.
// Configuration: cfg_wr_en/cfg_idx/cfg_wdata write a register; the user must write only
// while the block is idle, which the block does not enforce. Index 0 alarm duration (s),
// 1 cooldown (s), 2 motor stop keepalive period (ms); other indexes are ignored.
// Reset (arst_n low): both alarms off, timers and cooldowns cleared, keepalive
// counter saturated, indicators off, configuration back to 3 s / 2 s / 1000 ms,
// both stages empty.
module hazard_alarm_timer_with_cooldown #(
	parameter int TIMER_WIDTH = 18
) (
	input  logic                                 clk,
	input  logic                                 arst_n,

	input  logic                                 cfg_wr_en,
	input  logic [hatc_pkg::CFG_IDX_W-1:0]       cfg_idx,
	input  logic [hatc_pkg::CFG_DATA_W-1:0]      cfg_wdata,

	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [1:0]                           mode,
	input  logic [1:0]                           detection,
	input  logic [hatc_pkg::MS_W-1:0]            elapsed_ms,

	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic                                 auto_alarm_active,
	output logic                                 manual_alarm_active,
	output logic                                 red_led,
	output logic                                 buzzer,
	output logic                                 indicator_on_sent,
	output logic                                 indicator_off_sent,
	output logic [1:0]                           motor_stop_sends,
	output logic [1:0]                           nav_requests
);

	localparam int TW = TIMER_WIDTH;
	// product width for seconds * 1000 (255000 needs 18 bits)
	localparam int PW = (TW > 18) ? TW : 18;
	localparam logic [TW-1:0] TMAX = {TW{1'b1}};
	localparam logic [hatc_pkg::STOP_W-1:0] STOP_MAX = {hatc_pkg::STOP_W{1'b1}};

	typedef struct packed {
		logic          on;
		logic [TW-1:0] tmr;
		logic [TW-1:0] cool;
		logic          start;
		logic          stop;
	} chan_t;

	// configuration
	logic [hatc_pkg::SEC_W-1:0] duration_q;
	logic [hatc_pkg::SEC_W-1:0] cooldown_q;
	logic [hatc_pkg::MS_W-1:0]  resend_q;

	// alarm state
	logic                       man_on_q, auto_on_q;
	logic [TW-1:0]              man_tmr_q, auto_tmr_q;
	logic [TW-1:0]              man_cool_q, auto_cool_q;
	logic [hatc_pkg::STOP_W-1:0] since_stop_q;
	logic                       led_q, buzz_q;

	// input stage
	logic                       v_s1;
	logic [1:0]                 mode_s1;
	logic [1:0]                 det_s1;
	logic [hatc_pkg::MS_W-1:0]  ems_s1;

	logic advance;

	assign advance  = v_s1 && (!out_valid || out_ready);
	assign in_ready = !v_s1 || advance;

	function automatic logic [TW-1:0] clamp_ms(input logic [hatc_pkg::SEC_W-1:0] sec);
		logic [PW-1:0] ms;
		ms = PW'(sec) * PW'(hatc_pkg::MS_PER_SEC);
		return (ms > PW'(TMAX)) ? TMAX : ms[TW-1:0];
	endfunction

	function automatic logic [TW-1:0] sat_add(input logic [TW-1:0] a,
			input logic [hatc_pkg::MS_W-1:0] b);
		logic [TW:0] s;
		s = {1'b0, a} + (TW+1)'(b);
		return s[TW] ? TMAX : s[TW-1:0];
	endfunction

	function automatic logic [TW-1:0] floor_sub(input logic [TW-1:0] a,
			input logic [hatc_pkg::MS_W-1:0] b);
		return (a > TW'(b)) ? (a - TW'(b)) : '0;
	endfunction

	// one channel tick on already time-advanced state
	function automatic chan_t tick(input logic on, input logic [TW-1:0] tmr,
			input logic [TW-1:0] cool, input logic [1:0] det,
			input logic [TW-1:0] dur_ms, input logic [TW-1:0] cool_ms);
		chan_t r;
		logic  on1;
		r.start = (det == hatc_pkg::DET_DANGER) && !on && (cool == '0);
		on1     = on || r.start;
		r.tmr   = r.start ? '0 : tmr;
		r.stop  = on1 && ((r.tmr >= dur_ms) || (det == hatc_pkg::DET_CLEAR));
		r.on    = on1 && !r.stop;
		r.cool  = r.stop ? cool_ms : cool;
		return r;
	endfunction

	logic [TW-1:0]               dur_ms, cool_ms;
	logic [TW-1:0]               m_tmr, a_tmr, m_cool, a_cool;
	logic [hatc_pkg::STOP_W:0]   since_sum;
	logic [hatc_pkg::STOP_W-1:0] since_adv;
	chan_t                       ch;

	logic                        man_on_d, auto_on_d, led_d, buzz_d;
	logic [TW-1:0]               man_tmr_d, auto_tmr_d, man_cool_d, auto_cool_d;
	logic [hatc_pkg::STOP_W-1:0] since_d;
	logic                        on_sent_d, off_sent_d;
	logic [1:0]                  stops_d, navs_d;

	always_comb begin
		dur_ms  = clamp_ms(duration_q);
		cool_ms = clamp_ms(cooldown_q);

		m_tmr     = man_on_q ? sat_add(man_tmr_q, ems_s1) : man_tmr_q;
		a_tmr     = auto_on_q ? sat_add(auto_tmr_q, ems_s1) : auto_tmr_q;
		m_cool    = floor_sub(man_cool_q, ems_s1);
		a_cool    = floor_sub(auto_cool_q, ems_s1);
		since_sum = {1'b0, since_stop_q} + (hatc_pkg::STOP_W+1)'(ems_s1);
		since_adv = since_sum[hatc_pkg::STOP_W] ? STOP_MAX
			: since_sum[hatc_pkg::STOP_W-1:0];

		ch = tick((mode_s1 == hatc_pkg::MODE_AUTO) ? auto_on_q : man_on_q,
			(mode_s1 == hatc_pkg::MODE_AUTO) ? a_tmr : m_tmr,
			(mode_s1 == hatc_pkg::MODE_AUTO) ? a_cool : m_cool,
			det_s1, dur_ms, cool_ms);

		man_on_d    = man_on_q;
		auto_on_d   = auto_on_q;
		man_tmr_d   = m_tmr;
		auto_tmr_d  = a_tmr;
		man_cool_d  = m_cool;
		auto_cool_d = a_cool;
		since_d     = since_adv;
		led_d       = led_q;
		buzz_d      = buzz_q;
		on_sent_d   = 1'b0;
		off_sent_d  = 1'b0;
		stops_d     = 2'd0;
		navs_d      = 2'd0;

		case (mode_s1)
			hatc_pkg::MODE_MANUAL: begin
				man_on_d   = ch.on;
				man_tmr_d  = ch.tmr;
				man_cool_d = ch.cool;
			end
			hatc_pkg::MODE_AUTO: begin
				auto_on_d   = ch.on;
				auto_tmr_d  = ch.tmr;
				auto_cool_d = ch.cool;
				stops_d     = {1'b0, ch.start};
				if (ch.stop) begin
					navs_d = 2'd1;
				end else if (ch.on && (since_adv >= hatc_pkg::STOP_W'(resend_q))) begin
					since_d = '0;
					stops_d = stops_d + 2'd1;
				end
				if (!ch.on)
					navs_d = navs_d + 2'd1;
			end
			hatc_pkg::MODE_RESET: begin
				man_on_d   = 1'b0;
				auto_on_d  = 1'b0;
				led_d      = 1'b0;
				buzz_d     = 1'b0;
				off_sent_d = 1'b1;
			end
			default: ;
		endcase

		// shared indicators follow whichever channel ticked
		if (mode_s1 == hatc_pkg::MODE_MANUAL || mode_s1 == hatc_pkg::MODE_AUTO) begin
			on_sent_d  = ch.start;
			off_sent_d = ch.stop;
			if (ch.start) begin
				led_d  = 1'b1;
				buzz_d = 1'b1;
			end
			if (ch.stop) begin
				led_d  = 1'b0;
				buzz_d = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duration_q <= hatc_pkg::DURATION_RST;
			cooldown_q <= hatc_pkg::COOLDOWN_RST;
			resend_q   <= hatc_pkg::RESEND_RST;
		end else if (cfg_wr_en) begin
			case (cfg_idx)
				hatc_pkg::CFG_ALARM_DURATION: duration_q <= cfg_wdata[hatc_pkg::SEC_W-1:0];
				hatc_pkg::CFG_COOLDOWN:       cooldown_q <= cfg_wdata[hatc_pkg::SEC_W-1:0];
				hatc_pkg::CFG_STOP_RESEND:    resend_q   <= cfg_wdata[hatc_pkg::MS_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			v_s1 <= 1'b1;
		end else if (advance) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			mode_s1 <= mode;
			det_s1  <= detection;
			ems_s1  <= elapsed_ms;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			man_on_q     <= 1'b0;
			auto_on_q    <= 1'b0;
			man_tmr_q    <= '0;
			auto_tmr_q   <= '0;
			man_cool_q   <= '0;
			auto_cool_q  <= '0;
			since_stop_q <= STOP_MAX;
			led_q        <= 1'b0;
			buzz_q       <= 1'b0;
			out_valid    <= 1'b0;
		end else if (advance) begin
			man_on_q     <= man_on_d;
			auto_on_q    <= auto_on_d;
			man_tmr_q    <= man_tmr_d;
			auto_tmr_q   <= auto_tmr_d;
			man_cool_q   <= man_cool_d;
			auto_cool_q  <= auto_cool_d;
			since_stop_q <= since_d;
			led_q        <= led_d;
			buzz_q       <= buzz_d;
			out_valid    <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			indicator_on_sent  <= on_sent_d;
			indicator_off_sent <= off_sent_d;
			motor_stop_sends   <= stops_d;
			nav_requests       <= navs_d;
		end
	end

	assign auto_alarm_active   = auto_on_q;
	assign manual_alarm_active = man_on_q;
	assign red_led             = led_q;
	assign buzzer              = buzz_q;

	// an on command without an off command leaves the indicators lit
	a_on_lights: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && indicator_on_sent && !indicator_off_sent |-> red_led && buzzer)
		else $error("indicator on sent but indicators dark");

	// two stops in one step need a start plus keepalive, so the alarm stays active
	a_two_stops: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && motor_stop_sends == 2'd2 |-> auto_alarm_active)
		else $error("double motor stop without active auto alarm");

	// a staged transaction is held while the result register is stalled
	a_stage_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && out_valid && !out_ready |=> v_s1 && $stable(mode_s1) && $stable(ems_s1))
		else $error("input stage lost a transaction during stall");

	// the alarm state changes only when a transaction advances
	a_state_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(auto_on_q) && $stable(man_on_q) && $stable(since_stop_q))
		else $error("alarm state changed without a transaction");

endmodule

/* sim/alarm_call_checker.sv */
module alarm_call_checker
	import hatc_pkg::*;
#(
	parameter int TIMER_WIDTH = 18
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  logic [1:0]           mode,
	input  logic [1:0]           detection,
	input  logic [MS_W-1:0]      elapsed_ms,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  logic                 auto_alarm_active,
	input  logic                 manual_alarm_active,
	input  logic                 red_led,
	input  logic                 buzzer,
	input  logic                 indicator_on_sent,
	input  logic                 indicator_off_sent,
	input  logic [1:0]           motor_stop_sends,
	input  logic [1:0]           nav_requests,
	output int                   mismatches,
	output int                   results_owed
);

	localparam longint TIMER_MAX = (longint'(1) << TIMER_WIDTH) - 1;
	localparam longint STOP_MAX  = (longint'(1) << STOP_W) - 1;
	localparam int     CH_MANUAL = 0;
	localparam int     CH_AUTO   = 1;

	typedef struct packed {
		logic       auto_on;
		logic       manual_on;
		logic       led;
		logic       buzz;
		logic       on_sent;
		logic       off_sent;
		logic [1:0] stops;
		logic [1:0] navs;
	} alarm_report_t;

	logic [SEC_W-1:0]       duration_sec;
	logic [SEC_W-1:0]       cool_len_sec;
	logic [MS_W-1:0]        resend_ms;
	logic                   ch_on [2];
	logic [TIMER_WIDTH-1:0] ch_timer [2];
	logic [TIMER_WIDTH-1:0] ch_cool [2];
	logic [STOP_W-1:0]      since_stop;
	logic                   led_lvl;
	logic                   buzz_lvl;
	alarm_report_t          owed_q [$];
	int                     fail_total = 0;

	assign mismatches = fail_total;

	function automatic longint sat_add(input longint a, input longint b, input longint lim);
		return (a + b > lim) ? lim : a + b;
	endfunction

	function automatic logic [TIMER_WIDTH-1:0] sec_to_ms(input logic [SEC_W-1:0] sec);
		longint ms;
		ms = longint'(sec) * longint'(MS_PER_SEC);
		return TIMER_WIDTH'((ms > TIMER_MAX) ? TIMER_MAX : ms);
	endfunction

	// bit 0: alarm started, bit 1: alarm ended
	function automatic logic [1:0] tick_channel(input int ch, input logic [1:0] det);
		logic [1:0] r;
		r = 2'b00;
		if (det == DET_DANGER && !ch_on[ch] && ch_cool[ch] == '0) begin
			ch_on[ch] = 1'b1;
			ch_timer[ch] = '0;
			led_lvl = 1'b1;
			buzz_lvl = 1'b1;
			r[0] = 1'b1;
		end
		if (ch_on[ch] && (ch_timer[ch] >= sec_to_ms(duration_sec) || det == DET_CLEAR)) begin
			ch_on[ch] = 1'b0;
			ch_cool[ch] = sec_to_ms(cool_len_sec);
			led_lvl = 1'b0;
			buzz_lvl = 1'b0;
			r[1] = 1'b1;
		end
		return r;
	endfunction

	function automatic alarm_report_t predict_call(input logic [1:0] m, input logic [1:0] det,
			input logic [MS_W-1:0] e);
		alarm_report_t rep;
		logic [1:0] st;
		logic was_on;
		rep = '0;
		// time advances first, whatever the mode
		for (int ch = 0; ch < 2; ch++) begin
			if (ch_on[ch])
				ch_timer[ch] = TIMER_WIDTH'(sat_add(longint'(ch_timer[ch]), longint'(e),
					TIMER_MAX));
			ch_cool[ch] = (ch_cool[ch] > e) ? ch_cool[ch] - e : '0;
		end
		since_stop = STOP_W'(sat_add(longint'(since_stop), longint'(e), STOP_MAX));
		case (m)
			MODE_MANUAL: begin
				st = tick_channel(CH_MANUAL, det);
				rep.on_sent = st[0];
				rep.off_sent = st[1];
			end
			MODE_AUTO: begin
				was_on = ch_on[CH_AUTO];
				st = tick_channel(CH_AUTO, det);
				rep.on_sent = st[0];
				rep.off_sent = st[1];
				if (!was_on && st[0])
					rep.stops = rep.stops + 2'd1;
				if (st[1]) begin
					rep.navs = rep.navs + 2'd1;
				end else if (ch_on[CH_AUTO] && since_stop >= resend_ms) begin
					since_stop = '0;
					rep.stops = rep.stops + 2'd1;
				end
				if (!ch_on[CH_AUTO])
					rep.navs = rep.navs + 2'd1;
			end
			MODE_RESET: begin
				ch_on[CH_MANUAL] = 1'b0;
				ch_on[CH_AUTO] = 1'b0;
				led_lvl = 1'b0;
				buzz_lvl = 1'b0;
				rep.off_sent = 1'b1;
			end
			default: ;
		endcase
		rep.auto_on = ch_on[CH_AUTO];
		rep.manual_on = ch_on[CH_MANUAL];
		rep.led = led_lvl;
		rep.buzz = buzz_lvl;
		return rep;
	endfunction

	task automatic compare_field(input string field, input logic [1:0] want, input logic [1:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", field, want, got);
			fail_total++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		alarm_report_t got;
		alarm_report_t want;
		if (!arst_n) begin
			duration_sec = DURATION_RST;
			cool_len_sec = COOLDOWN_RST;
			resend_ms = RESEND_RST;
			for (int ch = 0; ch < 2; ch++) begin
				ch_on[ch] = 1'b0;
				ch_timer[ch] = '0;
				ch_cool[ch] = '0;
			end
			since_stop = '1;
			led_lvl = 1'b0;
			buzz_lvl = 1'b0;
			owed_q.delete();
			results_owed <= 0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_idx)
					CFG_ALARM_DURATION: duration_sec = cfg_wdata[SEC_W-1:0];
					CFG_COOLDOWN:       cool_len_sec = cfg_wdata[SEC_W-1:0];
					CFG_STOP_RESEND:    resend_ms = cfg_wdata[MS_W-1:0];
					default: ;
				endcase
			end
			// a result always belongs to an earlier call, so check before queuing
			if (out_valid && out_ready) begin
				got = {auto_alarm_active, manual_alarm_active, red_led, buzzer,
					indicator_on_sent, indicator_off_sent, motor_stop_sends, nav_requests};
				if (owed_q.size() == 0) begin
					$error("result transaction with no call outstanding");
					fail_total++;
				end else begin
					want = owed_q.pop_front();
					compare_field("auto_alarm_active", 2'(want.auto_on), 2'(got.auto_on));
					compare_field("manual_alarm_active", 2'(want.manual_on),
						2'(got.manual_on));
					compare_field("red_led", 2'(want.led), 2'(got.led));
					compare_field("buzzer", 2'(want.buzz), 2'(got.buzz));
					compare_field("indicator_on_sent", 2'(want.on_sent), 2'(got.on_sent));
					compare_field("indicator_off_sent", 2'(want.off_sent),
						2'(got.off_sent));
					compare_field("motor_stop_sends", want.stops, got.stops);
					compare_field("nav_requests", want.navs, got.navs);
				end
			end
			if (in_valid && in_ready)
				owed_q.push_back(predict_call(mode, detection, elapsed_ms));
			results_owed <= owed_q.size();
		end
	end

endmodule

/* sim/hazard_alarm_timer_with_cooldown_tb.sv */
module hazard_alarm_timer_with_cooldown_tb;
	import hatc_pkg::*;

	localparam int         TW         = 18;
	localparam int         LONG_HOLD  = 40;
	localparam int         PHASE_LEN  = 105;
	localparam logic [1:0] MODE_IDLE  = 2'd3;
	localparam logic [1:0] DET_NONE   = 2'd0;
	localparam logic [1:0] DET_UNUSED = 2'd3;
	localparam logic [1:0] CFG_UNUSED = 2'd3;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	logic                  in_valid;
	logic                  in_ready;
	logic [1:0]            mode;
	logic [1:0]            detection;
	logic [MS_W-1:0]       elapsed_ms;
	logic                  out_valid;
	logic                  out_ready;
	logic                  auto_alarm_active;
	logic                  manual_alarm_active;
	logic                  red_led;
	logic                  buzzer;
	logic                  indicator_on_sent;
	logic                  indicator_off_sent;
	logic [1:0]            motor_stop_sends;
	logic [1:0]            nav_requests;
	int                    fail_count;
	int                    results_owed;
	bit                    calm = 1'b0;
	bit                    hold_request = 1'b0;

	hazard_alarm_timer_with_cooldown #(.TIMER_WIDTH(TW)) dut (.*);

	alarm_call_checker #(.TIMER_WIDTH(TW)) checker_i (
		.*,
		.mismatches(fail_count),
		.results_owed(results_owed)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#2_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	task automatic send_call(input logic [1:0] m, input logic [1:0] det, input logic [MS_W-1:0] e);
		int gap;
		if (!calm && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 3);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		detection <= det;
		elapsed_ms <= e;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic send_random_call(input int span_ms);
		int r;
		logic [1:0] m;
		logic [1:0] det;
		logic [MS_W-1:0] e;
		r = $urandom_range(0, 99);
		m = (r < 45) ? MODE_AUTO : (r < 85) ? MODE_MANUAL : (r < 95) ? MODE_RESET : MODE_IDLE;
		r = $urandom_range(0, 99);
		det = (r < 40) ? DET_NONE : (r < 75) ? DET_DANGER : (r < 93) ? DET_CLEAR : DET_UNUSED;
		r = $urandom_range(0, 99);
		e = (r < 10) ? '0 : (r < 80) ? MS_W'($urandom_range(0, span_ms)) :
			(r < 92) ? MS_W'($urandom) : '1;
		send_call(m, det, e);
	endtask

	// stop offering calls and wait out every outstanding result
	task automatic drain_calls();
		in_valid <= 1'b0;
		do @(posedge clk); while (results_owed != 0);
		repeat (2) @(posedge clk);
	endtask

	task automatic set_config(input logic [SEC_W-1:0] dur, input logic [SEC_W-1:0] cool,
			input logic [MS_W-1:0] resend);
		cfg_wr_en <= 1'b1;
		cfg_idx <= CFG_ALARM_DURATION;
		cfg_wdata <= {8'($urandom), dur};
		@(posedge clk);
		cfg_idx <= CFG_COOLDOWN;
		cfg_wdata <= {8'($urandom), cool};
		@(posedge clk);
		cfg_idx <= CFG_STOP_RESEND;
		cfg_wdata <= resend;
		@(posedge clk);
		// unmapped index, must be ignored
		cfg_idx <= CFG_UNUSED;
		cfg_wdata <= 16'($urandom);
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// receiver side: random stalls plus one long hold-off on request
	initial begin
		@(posedge clk);
		forever begin
			if (hold_request) begin
				hold_request = 1'b0;
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else if (!calm && $urandom_range(0, 4) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 3)) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_idx = '0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		mode = MODE_MANUAL;
		detection = DET_NONE;
		elapsed_ms = '0;
		out_ready = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset configuration: 3 s alarm, 2 s cooldown, 1000 ms keepalive
		send_call(MODE_IDLE, DET_UNUSED, 16'd0);
		send_call(MODE_AUTO, DET_NONE, 16'd0);
		send_call(MODE_AUTO, DET_DANGER, 16'd100);
		send_call(MODE_AUTO, DET_NONE, 16'd1000);
		send_call(MODE_MANUAL, DET_DANGER, 16'd1500);
		send_call(MODE_AUTO, DET_UNUSED, 16'hFFFF);
		send_call(MODE_AUTO, DET_DANGER, 16'd500);
		send_call(MODE_MANUAL, DET_CLEAR, 16'd0);
		send_call(MODE_RESET, DET_DANGER, 16'd0);
		send_call(MODE_MANUAL, DET_DANGER, 16'hFFFF);
		send_call(MODE_RESET, DET_CLEAR, 16'd0);
		send_call(MODE_IDLE, DET_DANGER, 16'hFFFF);
		send_call(MODE_AUTO, DET_DANGER, 16'hFFFF);
		send_call(MODE_AUTO, DET_CLEAR, 16'd0);

		// zero duration, cooldown and keepalive
		drain_calls();
		set_config(8'd0, 8'd0, 16'd0);
		send_call(MODE_AUTO, DET_DANGER, 16'd0);
		send_call(MODE_AUTO, DET_DANGER, 16'd0);
		send_call(MODE_MANUAL, DET_DANGER, 16'd0);
		send_call(MODE_AUTO, DET_CLEAR, 16'd0);
		send_call(MODE_MANUAL, DET_NONE, 16'd7);

		// maximum settings, timers driven into saturation
		drain_calls();
		set_config(8'hFF, 8'hFF, 16'hFFFF);
		send_call(MODE_MANUAL, DET_DANGER, 16'd0);
		repeat (5) send_call(MODE_IDLE, DET_NONE, 16'hFFFF);
		send_call(MODE_MANUAL, DET_NONE, 16'd0);
		send_call(MODE_AUTO, DET_DANGER, 16'd0);
		send_call(MODE_AUTO, DET_NONE, 16'hFFFF);
		send_call(MODE_AUTO, DET_DANGER, 16'hFFFF);

		for (int p = 0; p < 5; p++) begin
			drain_calls();
			case (p)
				0: set_config(8'd2, 8'd1, 16'd0);
				1: set_config(8'($urandom_range(1, 4)), 8'($urandom_range(0, 3)),
					16'($urandom_range(100, 2000)));
				2: set_config(8'hFF, 8'hFF, 16'($urandom_range(30000, 65535)));
				3: set_config(8'($urandom_range(0, 4)), 8'($urandom_range(0, 2)), 16'd1);
				default: set_config(8'($urandom_range(1, 5)), 8'($urandom_range(0, 3)),
					16'($urandom_range(0, 3000)));
			endcase
			if (p == 1)
				hold_request = 1'b1;
			if (p == 4)
				calm = 1'b1;
			repeat (PHASE_LEN) send_random_call((p == 2) ? 65535 : 1200);
		end

		in_valid <= 1'b0;
		do @(posedge clk); while (results_owed != 0);
		repeat (4) @(posedge clk);
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
